>>> rtl/vms_pkg.sv
// ============================================================================
// vms_pkg: shared widths for the von Mises stress and gradient block
// Fixed output widths and the parameter defaults used by the top level.
// ============================================================================
package vms_pkg;

  localparam int STRESS_BITS_DEF    = 24;
  localparam int GRAD_FRAC_BITS_DEF = 16;
  localparam int VM_W               = 25;
  localparam int GRAD_W             = 18;

endpackage

>>> rtl/vms_core.sv
// ============================================================================
// vms_core: pipelined von Mises stress and gradient datapath
// Square stage, sum stage, one root bit per stage, then a restoring divider
// with one quotient bit per stage for all six gradients, then saturation.
// ============================================================================
module vms_core
  import vms_pkg::*;
#(
  parameter int SB = STRESS_BITS_DEF,
  parameter int FB = GRAD_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  logic signed [SB-1:0] nx_i,
  input  logic signed [SB-1:0] ny_i,
  input  logic signed [SB-1:0] nz_i,
  input  logic signed [SB-1:0] sxy_i,
  input  logic signed [SB-1:0] syz_i,
  input  logic signed [SB-1:0] sxz_i,
  output logic                 vld_o,
  output logic [VM_W-1:0]      vm_o,
  output logic [GRAD_W-1:0]    g_o [6],
  output logic                 zero_o
);

  // widths: differences SB+1 bits, squares 2SB+2, sum below 2^(2SB+5)
  localparam int DW  = SB + 1;
  localparam int SQW = 2 * DW;
  localparam int SW  = 2 * SB + 6;
  localparam int RW  = SW / 2;          // root bits
  localparam int NW  = SB + 3;          // gradient numerator magnitude
  localparam int DVW = RW + 1;          // divisor 2*vm
  localparam int QB  = GRAD_W;          // quotient bits kept (saturating)
  localparam int XW  = NW + FB;         // dividend width
  localparam int PW  = DVW + QB + 1;    // partial remainder width
  localparam logic [QB-1:0] QMAX = {1'b0, {(QB-1){1'b1}}};

  // ---------------- stage 1: differences and squares ----------------------
  logic              v1_r;
  logic [SQW-1:0]    sq_r [6];
  logic [NW-1:0]     num_r [6];
  logic [5:0]        neg_r;
  logic signed [DW:0] d [3];
  logic signed [NW-1:0] n [6];
  logic [DW-1:0]     m [6];

  always_comb begin
    d[0] = (DW+1)'(nx_i) - (DW+1)'(ny_i);
    d[1] = (DW+1)'(ny_i) - (DW+1)'(nz_i);
    d[2] = (DW+1)'(nz_i) - (DW+1)'(nx_i);
    n[0] = NW'(2 * NW'(nx_i) - NW'(ny_i) - NW'(nz_i));
    n[1] = NW'(2 * NW'(ny_i) - NW'(nx_i) - NW'(nz_i));
    n[2] = NW'(2 * NW'(nz_i) - NW'(nx_i) - NW'(ny_i));
    n[3] = NW'(3 * NW'(sxy_i));
    n[4] = NW'(3 * NW'(syz_i));
    n[5] = NW'(3 * NW'(sxz_i));
    for (int i = 0; i < 3; i++) m[i] = d[i][DW] ? DW'(-d[i]) : DW'(d[i]);
    m[3] = sxy_i[SB-1] ? DW'(-(DW'(sxy_i))) : DW'(sxy_i);
    m[4] = syz_i[SB-1] ? DW'(-(DW'(syz_i))) : DW'(syz_i);
    m[5] = sxz_i[SB-1] ? DW'(-(DW'(sxz_i))) : DW'(sxz_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= vld_i;
    for (int i = 0; i < 6; i++) begin
      sq_r[i]  <= SQW'(m[i]) * SQW'(m[i]);
      neg_r[i] <= n[i][NW-1];
      num_r[i] <= n[i][NW-1] ? NW'(-n[i]) : NW'(n[i]);
    end
  end

  // ---------------- stage 2: weighted sum ---------------------------------
  logic           v2_r;
  logic [SW-1:0]  s_r;
  logic [NW-1:0]  num2_r [6];
  logic [5:0]     neg2_r;
  logic [SW-1:0]  nsum, ssum;

  always_comb begin
    nsum = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    ssum = SW'(sq_r[3]) + SW'(sq_r[4]) + SW'(sq_r[5]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    s_r    <= (nsum >> 1) + ssum + (ssum << 1);
    num2_r <= num_r;
    neg2_r <= neg_r;
  end

  // ---------------- root stages: one bit per stage ------------------------
  logic          rv_r  [RW+1];
  logic [SW-1:0] rrem_r[RW+1];
  logic [RW-1:0] rq_r  [RW+1];
  logic [NW-1:0] rnum_r[RW+1][6];
  logic [5:0]    rneg_r[RW+1];

  always_comb begin
    rv_r[0]   = v2_r;
    rrem_r[0] = s_r;
    rq_r[0]   = '0;
    rnum_r[0] = num2_r;
    rneg_r[0] = neg2_r;
  end

  for (genvar k = 0; k < RW; k++) begin : g_root
    localparam int B = RW - 1 - k;
    logic [SW+1:0] trial;
    logic          fit;
    // (r + 2^B)^2 - r^2 = 2^B * (2r + 2^B)
    always_comb begin
      trial = ((SW+2)'(rq_r[k]) << (B + 1)) + ((SW+2)'(1) << (2 * B));
      fit   = trial <= (SW+2)'(rrem_r[k]);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) rv_r[k+1] <= 1'b0;
      else        rv_r[k+1] <= rv_r[k];
      rrem_r[k+1] <= fit ? SW'((SW+2)'(rrem_r[k]) - trial) : rrem_r[k];
      rq_r[k+1]   <= fit ? (rq_r[k] | (RW'(1) << B)) : rq_r[k];
      rnum_r[k+1] <= rnum_r[k];
      rneg_r[k+1] <= rneg_r[k];
    end
  end

  // ---------------- divider setup -----------------------------------------
  // quotient bit positions above QB saturate: preset by a high compare
  logic           dv_r  [QB+1];
  logic [RW-1:0]  dvm_r [QB+1];
  logic [PW-1:0]  prem_r[QB+1][6];
  logic [XW-1:0]  pdv_r [QB+1][6];
  logic [QB-1:0]  pq_r  [QB+1][6];
  logic [5:0]     povf_r[QB+1];
  logic [5:0]     pneg_r[QB+1];

  logic [DVW-1:0] den0 [6];
  logic [XW-1:0]  x0   [6];
  logic [5:0]     ovf0;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      den0[i] = (i < 3) ? {rq_r[RW], 1'b0} : DVW'(rq_r[RW]);
      x0[i]   = XW'(rnum_r[RW][i]) << FB;
      // quotient >= 2^QB iff high part of dividend >= den
      ovf0[i] = (XW'(x0[i] >> QB)) >= XW'(den0[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= rv_r[RW];
    dvm_r[0]  <= rq_r[RW];
    pneg_r[0] <= rneg_r[RW];
    povf_r[0] <= ovf0;
    for (int i = 0; i < 6; i++) begin
      // remainder holds high bits (already known < den when no overflow)
      prem_r[0][i] <= PW'(x0[i] >> QB);
      pdv_r[0][i]  <= x0[i];
      pq_r[0][i]   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [PW-1:0] sh [6];
    logic [PW-1:0] dn [6];
    logic          ge [6];
    always_comb begin
      for (int i = 0; i < 6; i++) begin
        dn[i] = (i < 3) ? PW'({dvm_r[k], 1'b0}) : PW'(dvm_r[k]);
        sh[i] = {prem_r[k][i][PW-2:0], pdv_r[k][i][B]};
        ge[i] = sh[i] >= dn[i];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else        dv_r[k+1] <= dv_r[k];
      dvm_r[k+1]  <= dvm_r[k];
      pneg_r[k+1] <= pneg_r[k];
      povf_r[k+1] <= povf_r[k];
      pdv_r[k+1]  <= pdv_r[k];
      for (int i = 0; i < 6; i++) begin
        prem_r[k+1][i] <= ge[i] ? sh[i] - dn[i] : sh[i];
        pq_r[k+1][i]   <= pq_r[k][i] | (ge[i] ? QB'(1) << B : QB'(0));
      end
    end
  end

  // ---------------- output stage: saturate, sign, zero flag ---------------
  logic              vo_r;
  logic [VM_W-1:0]   vmo_r;
  logic [GRAD_W-1:0] go_r [6];
  logic              zo_r;
  logic              z;
  logic [QB-1:0]     lim [6];
  logic [QB-1:0]     q   [6];

  // saturation bound depends on the sign
  always_comb begin
    z = dvm_r[QB] == '0;
    for (int i = 0; i < 6; i++) begin
      lim[i] = pneg_r[QB][i] ? QMAX + QB'(1) : QMAX;
      q[i]   = (povf_r[QB][i] || pq_r[QB][i] > lim[i]) ? lim[i] : pq_r[QB][i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else        vo_r <= dv_r[QB];
    zo_r <= z;
    if (RW > VM_W && (dvm_r[QB] >> VM_W) != '0) vmo_r <= '1;
    else vmo_r <= VM_W'(dvm_r[QB]);
    for (int i = 0; i < 6; i++) begin
      if (z) go_r[i] <= '0;
      else   go_r[i] <= pneg_r[QB][i] ? GRAD_W'(-q[i]) : GRAD_W'(q[i]);
    end
  end

  assign vld_o  = vo_r;
  assign vm_o   = vmo_r;
  assign g_o    = go_r;
  assign zero_o = zo_r;

endmodule

>>> rtl/von_mises_stress_and_gradient.sv
// ============================================================================
// von_mises_stress_and_gradient: pipelined equivalent stress and gradient
// ----------------------------------------------------------------------------
// Request channel: present six signed stress components with start high;
// busy is always low, so a request is taken every cycle start is high.
// Result channel: out_valid pulses for one cycle with the equivalent stress
// (floor of the square root), six signed fixed-point gradients and the
// zero_stress flag. Results leave in request order.
// Pipeline: STRESS_BITS+3 root stages plus 18 divider stages plus four
// fixed stages (squares, sum, divider setup, output). Throughput: one
// request per cycle, set by the fully unrolled root and restoring-divide
// pipelines.
// Reset clears all valid bits; requests in flight are dropped.
// The receiver cannot stall; every result is presented exactly once.
// ============================================================================
module von_mises_stress_and_gradient
  import vms_pkg::*;
#(
  parameter int STRESS_BITS    = STRESS_BITS_DEF,
  parameter int GRAD_FRAC_BITS = GRAD_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [STRESS_BITS-1:0] in_normal_x,
  input  logic signed [STRESS_BITS-1:0] in_normal_y,
  input  logic signed [STRESS_BITS-1:0] in_normal_z,
  input  logic signed [STRESS_BITS-1:0] in_shear_xy,
  input  logic signed [STRESS_BITS-1:0] in_shear_yz,
  input  logic signed [STRESS_BITS-1:0] in_shear_xz,
  output logic                          out_valid,
  output logic [VM_W-1:0]               out_equivalent_stress,
  output logic signed [GRAD_W-1:0]      out_grad_normal_x,
  output logic signed [GRAD_W-1:0]      out_grad_normal_y,
  output logic signed [GRAD_W-1:0]      out_grad_normal_z,
  output logic signed [GRAD_W-1:0]      out_grad_shear_xy,
  output logic signed [GRAD_W-1:0]      out_grad_shear_yz,
  output logic signed [GRAD_W-1:0]      out_grad_shear_xz,
  output logic                          out_zero_stress
);

  logic [GRAD_W-1:0] g [6];

  // fully pipelined, never stalls
  assign busy = 1'b0;

  vms_core #(.SB(STRESS_BITS), .FB(GRAD_FRAC_BITS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (start),
    .nx_i   (in_normal_x),
    .ny_i   (in_normal_y),
    .nz_i   (in_normal_z),
    .sxy_i  (in_shear_xy),
    .syz_i  (in_shear_yz),
    .sxz_i  (in_shear_xz),
    .vld_o  (out_valid),
    .vm_o   (out_equivalent_stress),
    .g_o    (g),
    .zero_o (out_zero_stress)
  );

  assign out_grad_normal_x = g[0];
  assign out_grad_normal_y = g[1];
  assign out_grad_normal_z = g[2];
  assign out_grad_shear_xy = g[3];
  assign out_grad_shear_yz = g[4];
  assign out_grad_shear_xz = g[5];

endmodule

>>> dv/tb.sv
// ============================================================================
// tb: self-checking bench for von_mises_stress_and_gradient
// Drives a table of hand-picked stress requests, then random ones under
// varying sender gaps, and checks every result field against an in-bench
// model of the equivalent stress and its fixed-point gradients.
// ============================================================================
module tb;
  import vms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = STRESS_BITS_DEF;
  localparam int GF = GRAD_FRAC_BITS_DEF;
  localparam int N_DIR = 14;
  localparam int N_RND = 1040;

  typedef logic signed [SB-1:0] stress_t;

  typedef struct packed {
    logic [VM_W-1:0]          vm;
    logic signed [GRAD_W-1:0] gnx, gny, gnz, gxy, gyz, gxz;
    logic                     zero;
  } vm_result_t;

  typedef struct {
    stress_t    s [6];
    logic       known;
    vm_result_t res;
  } stim_row_t;

  logic clk, rst_n, start, busy;
  stress_t in_nx, in_ny, in_nz, in_sxy, in_syz, in_sxz;
  logic out_valid, out_zero_stress;
  logic [VM_W-1:0] out_vm;
  logic signed [GRAD_W-1:0] o_gnx, o_gny, o_gnz, o_gxy, o_gyz, o_gxz;

  vm_result_t pending_results [$];
  int         mismatches;
  int         idle_pct;

  von_mises_stress_and_gradient DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_normal_x(in_nx), .in_normal_y(in_ny), .in_normal_z(in_nz),
    .in_shear_xy(in_sxy), .in_shear_yz(in_syz), .in_shear_xz(in_sxz),
    .out_valid(out_valid), .out_equivalent_stress(out_vm),
    .out_grad_normal_x(o_gnx), .out_grad_normal_y(o_gny), .out_grad_normal_z(o_gnz),
    .out_grad_shear_xy(o_gxy), .out_grad_shear_yz(o_gyz), .out_grad_shear_xz(o_gxz),
    .out_zero_stress(out_zero_stress)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // floor square root, bit by bit
  function automatic longint unsigned floor_root(logic [71:0] s);
    logic [71:0] r, c;
    r = '0;
    for (int k = 35; k >= 0; k--) begin
      c = r | (72'd1 << k);
      if (c * c <= s) r = c;
    end
    return r[63:0];
  endfunction

  // trunc(num * 2^GF / den), saturated to the gradient range
  function automatic logic signed [GRAD_W-1:0] grad_q(longint num, longint unsigned den);
    logic [95:0] mag, q;
    logic        neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag << GF) / den;
    if (neg) begin
      if (q > (96'd1 << (GRAD_W - 1))) q = 96'd1 << (GRAD_W - 1);
      return -q[GRAD_W-1:0];
    end
    if (q > (96'd1 << (GRAD_W - 1)) - 1) q = (96'd1 << (GRAD_W - 1)) - 1;
    return q[GRAD_W-1:0];
  endfunction

  function automatic vm_result_t stress_and_gradient(stress_t s [6]);
    longint nx, ny, nz, txy, tyz, txz;
    logic [71:0] sum;
    longint unsigned root;
    vm_result_t r;
    nx = s[0]; ny = s[1]; nz = s[2]; txy = s[3]; tyz = s[4]; txz = s[5];
    sum = (72'((nx - ny) * (nx - ny)) + 72'((ny - nz) * (ny - nz))
           + 72'((nz - nx) * (nz - nx))) >> 1;
    sum += 72'(3) * (72'(txy * txy) + 72'(tyz * tyz) + 72'(txz * txz));
    root = floor_root(sum);
    r = '0;
    r.vm = (root > (2 ** VM_W) - 1) ? '1 : root[VM_W-1:0];
    if (root == 0) begin
      r.zero = 1'b1;
      return r;
    end
    r.gnx = grad_q(2 * nx - ny - nz, 2 * root);
    r.gny = grad_q(2 * ny - nx - nz, 2 * root);
    r.gnz = grad_q(2 * nz - nx - ny, 2 * root);
    r.gxy = grad_q(3 * txy, root);
    r.gyz = grad_q(3 * tyz, root);
    r.gxz = grad_q(3 * txz, root);
    return r;
  endfunction

  // Issue one request, holding start until it is taken
  task automatic send_request(stress_t s [6], vm_result_t exp_res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_nx <= s[0]; in_ny <= s[1]; in_nz <= s[2];
    in_sxy <= s[3]; in_syz <= s[4]; in_sxz <= s[5];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results = {pending_results, exp_res};
  endtask

  function automatic stress_t rand_stress(int mode);
    case (mode)
      0: return stress_t'($urandom);
      1: return stress_t'(int'($urandom_range(0, 64)) - 32);
      2: return stress_t'(int'($urandom_range(0, 4000)) - 2000);
      default: return ($urandom_range(1)) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    vm_result_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_vm, o_gnx, o_gny, o_gnz, o_gxy, o_gyz, o_gxz, out_zero_stress};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t  rows [N_DIR];
    stress_t    s [6];
    stress_t    maxp, maxn;
    int         mode;
    vm_result_t er;
    maxp = {1'b0, {(SB-1){1'b1}}};
    maxn = {1'b1, {(SB-1){1'b0}}};
    mismatches = 0;
    idle_pct = 0;
    rst_n = 1'b0; start = 1'b0;
    in_nx = '0; in_ny = '0; in_nz = '0; in_sxy = '0; in_syz = '0; in_sxz = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: zero stress, hydrostatic, unit cases, extremes
    er = '0; er.zero = 1'b1;
    rows[0] = '{'{0, 0, 0, 0, 0, 0}, 1, er};
    rows[1] = '{'{100, 100, 100, 0, 0, 0}, 1, er};
    rows[2] = '{'{maxn, maxn, maxn, 0, 0, 0}, 1, er};
    rows[3] = '{'{1, 0, 0, 0, 0, 0}, 0, er};
    rows[4] = '{'{0, 0, 0, 1, 0, 0}, 0, er};
    rows[5] = '{'{0, 0, 0, 0, -1, 0}, 0, er};
    rows[6] = '{'{0, 0, 0, 0, 0, maxn}, 0, er};
    rows[7] = '{'{maxp, maxn, 0, 0, 0, 0}, 0, er};
    rows[8] = '{'{maxn, maxp, maxp, maxn, maxn, maxn}, 0, er};
    rows[9] = '{'{maxp, maxp, maxp, maxp, maxp, maxp}, 0, er};
    rows[10] = '{'{-1, -1, -1, -1, -1, -1}, 0, er};
    rows[11] = '{'{0, 1, -1, 0, 0, 0}, 0, er};
    rows[12] = '{'{maxp, 0, maxn, 1, -1, 2}, 0, er};
    rows[13] = '{'{3, -5, 7, -2, 4, -6}, 0, er};
    foreach (rows[i])
      send_request(rows[i].s, rows[i].known ? rows[i].res : stress_and_gradient(rows[i].s));

    // Random part in three idling phases
    for (int n = 0; n < N_RND; n++) begin
      idle_pct = (n < N_RND / 3) ? 32 : (n < 2 * N_RND / 3) ? 70 : 0;
      mode = $urandom_range(0, 3);
      foreach (s[k]) s[k] = ($urandom_range(0, 9) == 0) ? rand_stress($urandom_range(0, 3))
                                                        : rand_stress(mode);
      if ($urandom_range(0, 19) == 0) begin
        s[1] = s[0]; s[2] = s[0];
        s[3] = '0; s[4] = '0; s[5] = '0;
      end
      send_request(s, stress_and_gradient(s));
    end
    start <= 1'b0;

    // Drain, then allow the pipeline latency to pass
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> von_mises_stress_and_gradient.f
rtl/vms_pkg.sv
rtl/vms_core.sv
rtl/von_mises_stress_and_gradient.sv
dv/tb.sv
